// ----- sv/mexp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and constants of the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int FIELD_W = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT_RED,
        S_STEP,
        S_WAIT_MUL,
        S_DONE
    } t_state;

endpackage

// ----- sv/mexp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_in_if / mexp_out_if
// valid/ready channels for operand beats and result beats
// ----------------------------------------------------------------------------
interface mexp_in_if;
    import mexp_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] exponent;
    modport source (output valid, base_value, exponent, input ready);
    modport sink   (input valid, base_value, exponent, output ready);
endinterface

interface mexp_out_if;
    import mexp_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] power_result;
    modport source (output valid, power_result, input ready);
    modport sink   (input valid, power_result, output ready);
endinterface

// ----- sv/modular_exponentiation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// One beat is worked at a time. The base is first reduced in one pass through
// a row of OPERAND_WIDTH cells; then every exponent bit up to the highest set
// one takes a pass through the row that forms the multiply and the square side
// by side. A zero modulus gives 0 without a pass through the row. The next
// beat is taken while a finished result still waits at the output.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [mexp_pkg::FIELD_W-1:0] i_cfg_wdata,
    mexp_in_if.sink                  i_in,
    mexp_out_if.source               o_out
);
    import mexp_pkg::*;

    localparam int W = OPERAND_WIDTH;

    t_state       r_state, n_state;
    logic [W-1:0] r_m, r_e, n_e, r_b, n_b, r_acc, n_acc, r_res, n_res;
    logic [W-1:0] r_out, n_out;
    logic         r_ov, n_ov;

    logic         start;
    logic [W-1:0] a0, b0, a1, b1, one_m, acc_m;
    logic         done;
    logic [W-1:0] p0, p1;

    mexp_row #(.W(W)) u_row (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_m(r_m), .i_start(start),
        .i_a0(a0), .i_b0(b0), .i_a1(a1), .i_b1(b1),
        .o_done(done), .o_p0(p0), .o_p1(p1)
    );

    assign one_m = (r_m == W'(1)) ? '0 : W'(1);
    assign acc_m = (r_m == W'(1)) ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_m     <= W'(1);
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_m <= i_cfg_wdata[W-1:0];
            end
        end
        r_e   <= n_e;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_res <= n_res;
        r_out <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_e        = r_e;
        n_b        = r_b;
        n_acc      = r_acc;
        n_res      = r_res;
        n_out      = r_out;
        n_ov       = r_ov & ~o_out.ready;
        i_in.ready = 1'b0;
        start      = 1'b0;
        a0         = one_m;
        b0         = r_b;
        a1         = r_b;
        b1         = r_b;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                b0         = i_in.base_value[W-1:0];
                if (i_in.valid) begin
                    n_e   = i_in.exponent[W-1:0];
                    n_acc = W'(1);
                    if (r_m == '0) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        start   = 1'b1;
                        n_state = S_WAIT_RED;
                    end
                end
            end
            S_WAIT_RED: begin
                if (done) begin
                    n_b     = p0;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                a0 = acc_m;
                if (r_e == '0) begin
                    n_res   = r_acc;
                    n_state = S_DONE;
                end else begin
                    start   = 1'b1;
                    n_state = S_WAIT_MUL;
                end
            end
            S_WAIT_MUL: begin
                if (done) begin
                    if (r_e[0]) begin
                        n_acc = p0;
                    end
                    n_b     = p1;
                    n_e     = r_e >> 1;
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out.valid        = r_ov;
    assign o_out.power_result = FIELD_W'(r_out);

    a_no_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !done) else $error("row finished with no product pending");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state != S_IDLE) else $error("beat accepted but idle");
    a_base_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STEP |-> r_b < r_m) else $error("base power not reduced");
    a_exp_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT_MUL && done |=> r_e == ($past(r_e) >> 1))
        else $error("exponent not shifted");

endmodule

// ----- sv/mexp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_cell
// one shift-and-add step of a modular product, registered
// ----------------------------------------------------------------------------
module mexp_cell #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_m,
    input  logic         i_valid,
    input  logic [W-1:0] i_acc,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_valid,
    output logic [W-1:0] o_acc,
    output logic [W-1:0] o_a,
    output logic [W-1:0] o_b
);

    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] m);
        logic [W-1:0] gap;
        gap = m - y;
        return (x >= gap) ? (x - gap) : (x + y);
    endfunction

    logic         r_valid;
    logic [W-1:0] r_acc, r_a, r_b;
    logic [W-1:0] n_acc, dbl;

    always_comb begin
        dbl   = add_mod(i_acc, i_acc, i_m);
        n_acc = i_b[W-1] ? add_mod(dbl, i_a, i_m) : dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_acc <= n_acc;
        r_a   <= i_a;
        r_b   <= {i_b[W-2:0], 1'b0};
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_a     = r_a;
    assign o_b     = r_b;

endmodule

// ----- sv/mexp_row.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_row
// two lanes of W cells, each lane a pipelined modular multiplier
// ----------------------------------------------------------------------------
module mexp_row #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_m,
    input  logic         i_start,
    input  logic [W-1:0] i_a0,
    input  logic [W-1:0] i_b0,
    input  logic [W-1:0] i_a1,
    input  logic [W-1:0] i_b1,
    output logic         o_done,
    output logic [W-1:0] o_p0,
    output logic [W-1:0] o_p1
);

    logic [W:0]        v0, v1;
    logic [W-1:0]      acc0 [W+1];
    logic [W-1:0]      a0   [W+1];
    logic [W-1:0]      b0   [W+1];
    logic [W-1:0]      acc1 [W+1];
    logic [W-1:0]      a1   [W+1];
    logic [W-1:0]      b1   [W+1];

    assign v0[0] = i_start;
    assign v1[0] = i_start;
    assign acc0[0] = '0;
    assign acc1[0] = '0;
    assign a0[0] = i_a0;
    assign b0[0] = i_b0;
    assign a1[0] = i_a1;
    assign b1[0] = i_b1;

    for (genvar k = 0; k < W; k++) begin : g_cell
        mexp_cell #(.W(W)) u_c0 (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_m(i_m),
            .i_valid(v0[k]), .i_acc(acc0[k]), .i_a(a0[k]), .i_b(b0[k]),
            .o_valid(v0[k+1]), .o_acc(acc0[k+1]), .o_a(a0[k+1]), .o_b(b0[k+1])
        );
        mexp_cell #(.W(W)) u_c1 (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_m(i_m),
            .i_valid(v1[k]), .i_acc(acc1[k]), .i_a(a1[k]), .i_b(b1[k]),
            .o_valid(v1[k+1]), .o_acc(acc1[k+1]), .o_a(a1[k+1]), .o_b(b1[k+1])
        );
    end

    assign o_done = v0[W] & v1[W];
    assign o_p0   = acc0[W];
    assign o_p1   = acc1[W];

endmodule
